FILE: rtl/hcm_pkg.sv
package hcm_pkg;

  localparam int DEF_MAX_WIDTH   = 1024;
  localparam int DEF_SAMPLE_BITS = 16;

  localparam logic [16:0] ONE_Q16   = 17'h10000;
  // Cubic term of the smoothstep: 3.0 in Q2.16.
  localparam logic [17:0] THREE_Q16 = 18'h30000;

  localparam logic [10:0] RST_FRAME_WIDTH  = 11'd1024;
  localparam logic [15:0] RST_FRAME_HEIGHT = 16'd1024;
  localparam logic [31:0] RST_GAIN         = 32'd65536;
  localparam logic [1:0]  RST_MODE         = 2'd2;
  localparam logic [16:0] RST_RANGE_LOW    = 17'd0;
  localparam logic [16:0] RST_RANGE_HIGH   = 17'd65536;
  localparam logic [16:0] RST_FALLOFF      = 17'd6554;

  typedef enum logic [2:0] {
    REG_FRAME_WIDTH  = 3'd0,
    REG_FRAME_HEIGHT = 3'd1,
    REG_GAIN_X       = 3'd2,
    REG_GAIN_Y       = 3'd3,
    REG_MODE         = 3'd4,
    REG_RANGE_LOW    = 3'd5,
    REG_RANGE_HIGH   = 3'd6,
    REG_FALLOFF      = 3'd7
  } hcm_reg_t;

  typedef enum logic [1:0] {
    MODE_HORIZONTAL = 2'd0,
    MODE_VERTICAL   = 2'd1
  } hcm_mode_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_READ,
    ST_MUL_H,
    ST_MUL_V,
    ST_SELECT,
    ST_DIVIDE,
    ST_SQUARE,
    ST_CUBE,
    ST_FINISH,
    ST_OUTPUT
  } hcm_state_t;

endpackage

FILE: rtl/heightmap_curvature_mask_top.sv
// Convex curvature mask over a height grid streamed in raster order. Each input word is one
// height sample; the block answers one row late with a weight per cell, tagged with the cell's
// column and row, and the last row is emitted together with its own input. One item is handled
// at a time: a sample is accepted, then the line memory read-modify-write is done, and each
// result it causes (at most three) then takes two products through the shared multiplier, the
// range decision and the output load, with the bit-serial divider, the square, the cubic term
// and the finish in between when the value falls on a smoothstep ramp; the output register may
// also wait on out_tready. The two line memories hold MAX_WIDTH entries each and need no
// clearing pass; the row above is valid once the first row has been written, the row two above
// once the second has.
module heightmap_curvature_mask_top
  import hcm_pkg::*;
#(
  parameter int MAX_WIDTH   = DEF_MAX_WIDTH,
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
  parameter int IN_W        = ((SAMPLE_BITS + 7) / 8) * 8,
  parameter int COL_W       = $clog2(MAX_WIDTH),
  parameter int OUT_W       = ((17 + COL_W + 16 + 7) / 8) * 8
) (
  input  logic             clk,
  input  logic             rst_n,
  // height_sample
  input  logic [IN_W-1:0]  in_tdata,
  input  logic             in_tvalid,
  output logic             in_tready,
  // mask_value, out_col, out_row
  output logic [OUT_W-1:0] out_tdata,
  output logic             out_tlast,
  // frame_done
  output logic             out_tuser,
  output logic             out_tvalid,
  input  logic             out_tready,
  input  logic             cfg_psel,
  input  logic             cfg_penable,
  input  logic             cfg_pwrite,
  input  logic [4:0]       cfg_paddr,
  input  logic [31:0]      cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);

  localparam int SB   = SAMPLE_BITS;
  localparam int AW   = $clog2(MAX_WIDTH);
  localparam int WW   = $clog2(MAX_WIDTH + 1);
  localparam int DW   = SB + 2;
  localparam int MA_W = (SB + 1 > 18) ? SB + 1 : 18;
  localparam int PW   = MA_W + 32;
  localparam int SW   = PW - SB - 1;

  // Configuration registers.
  logic [10:0] fw_r;
  logic [15:0] fh_r;
  logic [31:0] gx_r, gy_r;
  logic [1:0]  mode_r;
  logic [16:0] rlo_r, rhi_r, fall_r;
  logic        cfg_we;
  hcm_reg_t    cfg_sel;

  assign cfg_pready = 1'b1;
  assign cfg_we     = cfg_psel & cfg_penable & cfg_pwrite;
  assign cfg_sel    = hcm_reg_t'(cfg_paddr[4:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fw_r   <= RST_FRAME_WIDTH;
      fh_r   <= RST_FRAME_HEIGHT;
      gx_r   <= RST_GAIN;
      gy_r   <= RST_GAIN;
      mode_r <= RST_MODE;
      rlo_r  <= RST_RANGE_LOW;
      rhi_r  <= RST_RANGE_HIGH;
      fall_r <= RST_FALLOFF;
    end else if (cfg_we) begin
      unique case (cfg_sel)
        REG_FRAME_WIDTH:  fw_r   <= cfg_pwdata[10:0];
        REG_FRAME_HEIGHT: fh_r   <= cfg_pwdata[15:0];
        REG_GAIN_X:       gx_r   <= cfg_pwdata;
        REG_GAIN_Y:       gy_r   <= cfg_pwdata;
        REG_MODE:         mode_r <= cfg_pwdata[1:0];
        REG_RANGE_LOW:    rlo_r  <= cfg_pwdata[16:0];
        REG_RANGE_HIGH:   rhi_r  <= cfg_pwdata[16:0];
        REG_FALLOFF:      fall_r <= cfg_pwdata[16:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_sel)
      REG_FRAME_WIDTH:  cfg_prdata = 32'(fw_r);
      REG_FRAME_HEIGHT: cfg_prdata = 32'(fh_r);
      REG_GAIN_X:       cfg_prdata = gx_r;
      REG_GAIN_Y:       cfg_prdata = gy_r;
      REG_MODE:         cfg_prdata = 32'(mode_r);
      REG_RANGE_LOW:    cfg_prdata = 32'(rlo_r);
      REG_RANGE_HIGH:   cfg_prdata = 32'(rhi_r);
      REG_FALLOFF:      cfg_prdata = 32'(fall_r);
      default:          cfg_prdata = '0;
    endcase
  end

  // Effective geometry.
  logic [31:0] fw32;
  logic [WW-1:0] w_eff;
  logic [15:0] h_eff;

  always_comb begin
    fw32 = 32'(fw_r);
    if (fw32 < 32'd2) w_eff = WW'(2);
    else if (fw32 > 32'(MAX_WIDTH)) w_eff = WW'(MAX_WIDTH);
    else w_eff = fw32[WW-1:0];
    h_eff = (fh_r < 16'd2) ? 16'd2 : fh_r;
  end

  hcm_state_t state_r, state_nxt;

  logic [AW-1:0] col_r;
  logic [15:0]   row_r;
  logic [AW-1:0] c_cur, rd_a1;
  logic [15:0]   r_cur;
  logic          in_acc;

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid & in_tready;

  always_comb begin
    c_cur = (WW'(col_r) >= w_eff) ? '0 : col_r;
    r_cur = (row_r >= h_eff) ? 16'd0 : row_r;
    rd_a1 = (WW'(c_cur) + WW'(1) < w_eff) ? c_cur + AW'(1) : c_cur;
  end

  // Item being worked on.
  logic [AW-1:0] c_r;
  logic [15:0]   r_r;
  logic [SB-1:0] s_r;

  always_ff @(posedge clk) begin
    if (in_acc) begin
      c_r <= c_cur;
      r_r <= r_cur;
      s_r <= in_tdata[SB-1:0];
    end
  end

  // Line memories: the row above and the row two above.
  logic [SB-1:0] ra_mem [MAX_WIDTH];
  logic [SB-1:0] rt_mem [MAX_WIDTH];
  logic [SB-1:0] ra_q0, ra_q1, rt_q;
  logic          mem_we;

  assign mem_we = (state_r == ST_READ);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      ra_mem[c_r] <= s_r;
      rt_mem[c_r] <= ra_q0;
    end
    ra_q0 <= ra_mem[c_cur];
    ra_q1 <= ra_mem[rd_a1];
    rt_q  <= rt_mem[c_cur];
  end

  // Window of the current and previous columns.
  logic [SB-1:0] win0_r, win1_r, win2_r;

  logic          last_row, first_col, last_col;
  assign last_row  = (r_r == h_eff - 16'd1);
  assign first_col = (c_r == '0);
  assign last_col  = (WW'(c_r) + WW'(1) == w_eff);

  // Up to three cells per item, kept in fixed slots.
  logic [SB-1:0]    sl_c [3];
  logic [SB-1:0]    sl_l [3];
  logic [SB-1:0]    sl_rt [3];
  logic [SB-1:0]    sl_u [3];
  logic [SB-1:0]    sl_d [3];
  logic [COL_W-1:0] sl_col [3];
  logic [15:0]      sl_row [3];
  logic [2:0]       sl_done;
  logic [2:0]       sl_en;
  logic [1:0]       idx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      win0_r <= '0;
      win1_r <= '0;
      win2_r <= '0;
      sl_en  <= '0;
    end else if (state_r == ST_READ) begin
      win0_r <= ra_q0;
      win1_r <= s_r;
      win2_r <= win1_r;
      sl_en[0] <= (r_r != 16'd0);
      sl_en[1] <= last_row && !first_col;
      sl_en[2] <= last_row && last_col;
      if (last_col) begin
        col_r <= '0;
        row_r <= (r_r + 16'd1 >= h_eff) ? 16'd0 : r_r + 16'd1;
      end else begin
        col_r <= c_r + AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_READ) begin
      sl_c[0]   <= ra_q0;
      sl_l[0]   <= first_col ? ra_q0 : win0_r;
      sl_rt[0]  <= last_col ? ra_q0 : ra_q1;
      sl_u[0]   <= (r_r >= 16'd2) ? rt_q : ra_q0;
      sl_d[0]   <= s_r;
      sl_col[0] <= COL_W'(c_r);
      sl_row[0] <= r_r - 16'd1;
      sl_done[0] <= 1'b0;

      sl_c[1]   <= win1_r;
      sl_l[1]   <= (c_r >= AW'(2)) ? win2_r : win1_r;
      sl_rt[1]  <= s_r;
      sl_u[1]   <= win0_r;
      sl_d[1]   <= win1_r;
      sl_col[1] <= COL_W'(c_r - AW'(1));
      sl_row[1] <= r_r;
      sl_done[1] <= 1'b0;

      sl_c[2]   <= s_r;
      sl_l[2]   <= win1_r;
      sl_rt[2]  <= s_r;
      sl_u[2]   <= ra_q0;
      sl_d[2]   <= s_r;
      sl_col[2] <= COL_W'(c_r);
      sl_row[2] <= r_r;
      sl_done[2] <= 1'b1;
    end
  end

  // Slot selection: the next enabled slot after the current one.
  logic       nxt_found;
  logic [1:0] nxt_idx;

  always_comb begin
    nxt_found = 1'b0;
    nxt_idx   = 2'd0;
    for (int k = 2; k >= 0; k--) begin
      if (sl_en[k] && 2'(k) > idx_r) begin
        nxt_found = 1'b1;
        nxt_idx   = 2'(k);
      end
    end
  end

  // Second differences of the current slot.
  logic signed [DW-1:0] d2h, d2v;
  always_comb begin
    d2h = $signed({1'b0, sl_c[idx_r], 1'b0}) - $signed({2'b00, sl_l[idx_r]})
        - $signed({2'b00, sl_rt[idx_r]});
    d2v = $signed({1'b0, sl_c[idx_r], 1'b0}) - $signed({2'b00, sl_u[idx_r]})
        - $signed({2'b00, sl_d[idx_r]});
  end

  // Shared multiplier.
  logic [MA_W-1:0] mul_a;
  logic [31:0]     mul_b;
  logic [PW-1:0]   prod_r;
  logic [15:0]     q_r;
  logic [15:0]     t2;

  assign t2 = prod_r[31:16];

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      ST_MUL_H: begin
        if (d2h > 0) mul_a = MA_W'(d2h[DW-2:0]);
        mul_b = gx_r;
      end
      ST_MUL_V: begin
        if (d2v > 0) mul_a = MA_W'(d2v[DW-2:0]);
        mul_b = gy_r;
      end
      ST_SQUARE: begin
        mul_a = MA_W'(q_r);
        mul_b = 32'(q_r);
      end
      ST_CUBE: begin
        mul_a = MA_W'(t2);
        mul_b = 32'(THREE_Q16 - {1'b0, q_r, 1'b0});
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    prod_r <= PW'(mul_a) * PW'(mul_b);
  end

  // Axis value: product scaled back and saturated at one.
  logic [SW-1:0] psh;
  logic [16:0]   axis_sat;
  assign psh      = prod_r[PW-1:SB+1];
  assign axis_sat = (psh > SW'(ONE_Q16)) ? ONE_Q16 : psh[16:0];

  // Range mapping.
  logic [16:0] h_r;
  logic [17:0] sel_v, lo, hi, fo;
  logic        in_range, ramp_lo, ramp_hi;

  always_comb begin
    case (mode_r)
      MODE_HORIZONTAL: sel_v = 18'(h_r);
      MODE_VERTICAL:   sel_v = 18'(axis_sat);
      default:         sel_v = (18'(h_r) + 18'(axis_sat)) >> 1;
    endcase
    lo = (rlo_r > ONE_Q16) ? 18'(ONE_Q16) : 18'(rlo_r);
    hi = (rhi_r > ONE_Q16) ? 18'(ONE_Q16) : 18'(rhi_r);
    if (hi < lo) hi = lo;
    fo = (fall_r > ONE_Q16) ? 18'(ONE_Q16) : 18'(fall_r);
    in_range = (sel_v >= lo) && (sel_v <= hi);
    ramp_lo  = (sel_v < lo) && (sel_v + fo > lo);
    ramp_hi  = (sel_v > hi) && (sel_v < hi + fo);
  end

  // Bit-serial divider and smoothstep finish.
  logic [16:0] rem_r, f_r, w_r;
  logic [3:0]  cnt_r;
  logic        rise_r;
  logic [17:0] rem2;
  logic        div_ge;
  logic [PW-17:0] wsh;
  logic [16:0] w_fin;

  assign rem2   = {rem_r, 1'b0};
  assign div_ge = rem2 >= {1'b0, f_r};
  assign wsh    = prod_r[PW-1:16];

  always_comb begin
    if (rise_r) begin
      w_fin = (wsh > (PW-16)'(ONE_Q16)) ? ONE_Q16 : wsh[16:0];
    end else begin
      w_fin = (wsh >= (PW-16)'(ONE_Q16)) ? 17'd0 : 17'(ONE_Q16 - wsh[16:0]);
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      ST_MUL_V: h_r <= axis_sat;
      ST_SELECT: begin
        rise_r <= ramp_lo;
        f_r    <= fo[16:0];
        q_r    <= '0;
        cnt_r  <= '0;
        rem_r  <= ramp_lo ? 17'(sel_v + fo - lo) : 17'(sel_v - hi);
        if (in_range) w_r <= ONE_Q16;
        else w_r <= '0;
      end
      ST_DIVIDE: begin
        rem_r <= div_ge ? 17'(rem2 - {1'b0, f_r}) : rem2[16:0];
        q_r   <= {q_r[14:0], div_ge};
        cnt_r <= cnt_r + 4'd1;
      end
      ST_FINISH: w_r <= w_fin;
      default: ;
    endcase
  end

  // Output register.
  logic             out_valid_r;
  logic [16:0]      om_mask_r;
  logic [COL_W-1:0] om_col_r;
  logic [15:0]      om_row_r;
  logic             om_last_r, om_done_r;
  logic             out_load;

  assign out_load = (state_r == ST_OUTPUT) && (!out_valid_r || out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      om_mask_r <= w_r;
      om_col_r  <= sl_col[idx_r];
      om_row_r  <= sl_row[idx_r];
      om_last_r <= !nxt_found;
      om_done_r <= sl_done[idx_r];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_W'({om_row_r, om_col_r, om_mask_r});
  assign out_tlast  = om_last_r;
  assign out_tuser  = om_done_r;

  // Sequencer. Slot 0 is enabled whenever any slot is, so every item starts there.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_READ) idx_r <= '0;
      else if (out_load && nxt_found) idx_r <= nxt_idx;
    end
  end

  logic any_en_now;
  assign any_en_now = (r_r != 16'd0) || last_row;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (in_acc) state_nxt = ST_READ;
      ST_READ:   state_nxt = any_en_now ? ST_MUL_H : ST_IDLE;
      ST_MUL_H:  state_nxt = ST_MUL_V;
      ST_MUL_V:  state_nxt = ST_SELECT;
      ST_SELECT: begin
        if (in_range || fo == 18'd0 || !(ramp_lo || ramp_hi)) state_nxt = ST_OUTPUT;
        else state_nxt = ST_DIVIDE;
      end
      ST_DIVIDE: if (cnt_r == 4'd15) state_nxt = ST_SQUARE;
      ST_SQUARE: state_nxt = ST_CUBE;
      ST_CUBE:   state_nxt = ST_FINISH;
      ST_FINISH: state_nxt = ST_OUTPUT;
      ST_OUTPUT: if (out_load) state_nxt = nxt_found ? ST_MUL_H : ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

endmodule

FILE: rtl/hcm_checker.sv
module hcm_checker
  import hcm_pkg::*;
#(
  parameter int OUT_W = 48
) (
  input logic             clk,
  input logic             rst_n,
  input logic             in_tvalid,
  input logic             in_tready,
  input logic [OUT_W-1:0] out_tdata,
  input logic             out_tlast,
  input logic             out_tuser,
  input logic             out_tvalid,
  input logic             out_tready
);

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result word dropped while stalled");

  // The end of the grid always closes the run of its input.
  a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tlast)
    else $error("frame end without end of run");

  // Weights never exceed one.
  a_mask_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[16:0] <= ONE_Q16)
    else $error("mask value above one");

  // One sample at a time: after an accept the input side closes.
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second sample taken while busy");

endmodule

bind heightmap_curvature_mask_top hcm_checker #(.OUT_W(OUT_W)) u_hcm_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast),
  .out_tuser  (out_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready)
);
